### hw/rtl/awk_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_pkg
// Shared types, constants and tables of the Ackermann wheel speed block.
// -----------------------------------------------------------------------------
package awk_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF   = 32;

   localparam logic [10:0] STRAIGHT_MRAD = 11'd1571;
   localparam int CORDIC_STEPS = 16;
   localparam int CW           = 48;
   localparam int ZW           = 18;
   localparam int XYW          = 29;
   localparam int DIV_QW       = 17;
   localparam int DIV_LAT      = DIV_QW + 1;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int BACK_LAT     = 4 + DIV_LAT;
   localparam int STEER_DLY    = BACK_LAT - 1 - CORDIC_LAT;

   localparam logic [1:0] ADDR_DRIVE_RATIO = 2'd0;
   localparam logic [1:0] ADDR_TRACK_WIDTH = 2'd1;
   localparam logic [1:0] ADDR_WHEELBASE   = 2'd2;
   localparam logic [1:0] ADDR_MIN_RADIUS  = 2'd3;

   typedef enum logic [1:0] {
      KIND_ZERO     = 2'd0,
      KIND_STRAIGHT = 2'd1,
      KIND_NORMAL   = 2'd2,
      KIND_CUT      = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] drive_ratio;
      logic [11:0] track_width;
      logic [11:0] wheelbase;
      logic [15:0] min_radius;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] v;
      logic signed [15:0] w;
      logic [16:0]        av;
      logic [16:0]        aw;
      logic               left;
      logic [24:0]        av1000;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic straight;
      logic left;
      logic negl;
      logic negr;
   } meta_type;

   function automatic logic signed [ZW-1:0] atan_tab(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = ZW'(51472);
         1:  r = ZW'(30385);
         2:  r = ZW'(16055);
         3:  r = ZW'(8150);
         4:  r = ZW'(4091);
         5:  r = ZW'(2047);
         6:  r = ZW'(1024);
         7:  r = ZW'(512);
         8:  r = ZW'(256);
         9:  r = ZW'(128);
         10: r = ZW'(64);
         11: r = ZW'(32);
         12: r = ZW'(16);
         13: r = ZW'(8);
         14: r = ZW'(4);
         15: r = ZW'(2);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/twist_to_ackermann_wheel_speeds.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// twist_to_ackermann_wheel_speeds
// Turns a twist command into a steering angle and rear wheel speeds.
//
// The req channel carries one item per command: linear speed (mm/s) and yaw
// rate (mrad/s). The rsp channel returns one item per command, in order:
// steering angle, left and right wheel speed, left and right motor rpm.
// The csr port sets drive ratio, track width, wheelbase and minimum radius.
// An item enters a two-stage classifier, waits in a short queue and then
// runs through a 22-stage arithmetic pipeline, whose length is set by the
// 16-step CORDIC and the 17-bit pipelined dividers. One item is taken per
// cycle when nothing stalls. The arithmetic pipeline never stops; items
// enter it only when the result queue has room reserved for them, so a
// stalled receiver fills the result queue, then the classifier queue, and
// then drops req_tready.
// Reset empties both queues and loads the register defaults.
// -----------------------------------------------------------------------------
module twist_to_ackermann_wheel_speeds
   import awk_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // linear_speed[15:0], yaw_rate[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // steer_angle[11:0], left_speed[27:12],
                                    // right_speed[43:28], left_rpm[60:44],
                                    // right_rpm[77:61], zero[79:78]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cfg_type cfg_ff, cfg_in;
   logic    wr;
   logic    fr_push, q_full, q_empty, q_pop;
   cmd_type fr_cmd, q_cmd;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            ADDR_DRIVE_RATIO: cfg_in.drive_ratio = csr_pwdata[15:0];
            ADDR_TRACK_WIDTH: cfg_in.track_width = csr_pwdata[11:0];
            ADDR_WHEELBASE:   cfg_in.wheelbase   = csr_pwdata[11:0];
            ADDR_MIN_RADIUS:  cfg_in.min_radius  = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
      case (csr_paddr[3:2])
         ADDR_DRIVE_RATIO: csr_prdata = {16'b0, cfg_ff.drive_ratio};
         ADDR_TRACK_WIDTH: csr_prdata = {20'b0, cfg_ff.track_width};
         ADDR_WHEELBASE:   csr_prdata = {20'b0, cfg_ff.wheelbase};
         ADDR_MIN_RADIUS:  csr_prdata = {16'b0, cfg_ff.min_radius};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_ratio <= 16'd1000;
         cfg_ff.track_width <= 12'd327;
         cfg_ff.wheelbase   <= 12'd300;
         cfg_ff.min_radius  <= 16'd350;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   awk_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .push(fr_push), .cmd(fr_cmd), .full(q_full));

   awk_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(QUEUE_DEPTH)) u_cmd_fifo (
      .clock(clock), .reset(reset), .push(fr_push), .din(fr_cmd), .pop(q_pop),
      .dout(q_cmd), .full(q_full), .empty(q_empty));

   awk_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd(q_cmd),
      .q_empty(q_empty), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
endmodule

### hw/rtl/awk_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_fifo
// Small synchronous first-in first-out queue with a combinational read port.
// -----------------------------------------------------------------------------
module awk_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [NW-1:0]    cnt_ff, cnt_in;

   assign full  = (cnt_ff == NW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hw/rtl/awk_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_front
// Accepts twist items, takes magnitudes and sorts each into a turn kind.
// -----------------------------------------------------------------------------
module awk_front
   import awk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   output logic        push,
   output cmd_type     cmd,
   input  logic        full
);
   logic               valid0_ff, valid1_ff;
   logic signed [15:0] v0_ff, w0_ff;
   logic [16:0]        av0_ff, aw0_ff;
   logic [24:0]        av1000_0_ff;
   logic [32:0]        rmaw0_ff;
   cmd_type            cmd_ff, cmd_in;
   logic               adv0, adv1;
   logic signed [15:0] v_c, w_c;
   logic [16:0]        av_c, aw_c;

   assign v_c  = req_tdata[15:0];
   assign w_c  = req_tdata[31:16];
   assign av_c = v_c[15] ? 17'(-{v_c[15], v_c}) : {1'b0, v_c};
   assign aw_c = w_c[15] ? 17'(-{w_c[15], w_c}) : {1'b0, w_c};

   assign adv1       = !valid1_ff || !full;
   assign adv0       = !valid0_ff || adv1;
   assign req_tready = adv0;
   assign push       = valid1_ff && !full;
   assign cmd        = cmd_ff;

   always_comb begin
      cmd_in.v      = v0_ff;
      cmd_in.w      = w0_ff;
      cmd_in.av     = av0_ff;
      cmd_in.aw     = aw0_ff;
      cmd_in.av1000 = av1000_0_ff;
      cmd_in.left   = (v0_ff[15] == w0_ff[15]);
      if (v0_ff == '0) begin
         cmd_in.kind = KIND_ZERO;
      end else if (w0_ff == '0) begin
         cmd_in.kind = KIND_STRAIGHT;
      end else if ({8'b0, av1000_0_ff} <= rmaw0_ff) begin
         cmd_in.kind = KIND_CUT;
      end else begin
         cmd_in.kind = KIND_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         v0_ff       <= v_c;
         w0_ff       <= w_c;
         av0_ff      <= av_c;
         aw0_ff      <= aw_c;
         av1000_0_ff <= 25'(av_c * 25'd1000);
         rmaw0_ff    <= 33'(cfg.min_radius * aw_c);
      end
      if (adv1) begin
         cmd_ff <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         if (adv0) begin
            valid0_ff <= req_tvalid;
         end
         if (adv1) begin
            valid1_ff <= valid0_ff;
         end
      end
   end
endmodule

### hw/rtl/awk_cordic.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_cordic
// Pipelined vectoring CORDIC giving atan(y/x) in mrad, one stage per step.
// -----------------------------------------------------------------------------
module awk_cordic
   import awk_pkg::*;
(
   input  logic            clock,
   input  logic [XYW-1:0]  x,
   input  logic [XYW-1:0]  y,
   output logic [10:0]     angle
);
   logic signed [CW-1:0] x_ff [1:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [1:CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff [1:CORDIC_STEPS];
   logic signed [CW-1:0] xi [CORDIC_STEPS];
   logic signed [CW-1:0] yi [CORDIC_STEPS];
   logic signed [ZW-1:0] zi [CORDIC_STEPS];
   logic [26:0]          p_ff;
   logic [16:0]          zc;
   logic [27:0]          rnd;
   logic [11:0]          m;
   logic [10:0]          angle_ff;

   function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] val,
                                                   input int s);
      logic signed [CW-1:0] mag;
      mag = val[CW-1] ? -val : val;
      mag = mag >>> s;
      return val[CW-1] ? -mag : mag;
   endfunction

   genvar k;
   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
         logic signed [CW-1:0] dx, dy;
         if (k == 0) begin : g_first
            assign xi[k] = $signed({{(CW - XYW - 16){1'b0}}, x, 16'b0});
            assign yi[k] = $signed({{(CW - XYW - 16){1'b0}}, y, 16'b0});
            assign zi[k] = '0;
         end else begin : g_next
            assign xi[k] = x_ff[k];
            assign yi[k] = y_ff[k];
            assign zi[k] = z_ff[k];
         end
         assign dx = shr_tz(yi[k], k);
         assign dy = shr_tz(xi[k], k);
         always_ff @(posedge clock) begin
            if (!yi[k][CW-1]) begin
               x_ff[k+1] <= xi[k] + dx;
               y_ff[k+1] <= yi[k] - dy;
               z_ff[k+1] <= zi[k] + atan_tab(k);
            end else begin
               x_ff[k+1] <= xi[k] - dx;
               y_ff[k+1] <= yi[k] + dy;
               z_ff[k+1] <= zi[k] - atan_tab(k);
            end
         end
      end
   endgenerate

   assign zc  = z_ff[CORDIC_STEPS][ZW-1] ? '0 : z_ff[CORDIC_STEPS][ZW-2:0];
   assign rnd = {1'b0, p_ff} + 28'd32768;
   assign m   = rnd[27:16];
   assign angle = angle_ff;

   always_ff @(posedge clock) begin
      p_ff     <= 27'(zc * 27'd1000);
      angle_ff <= (m > {1'b0, STRAIGHT_MRAD}) ? STRAIGHT_MRAD : m[10:0];
   end
endmodule

### hw/rtl/awk_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_div
// Pipelined restoring divider, one quotient bit per stage, with a leading
// stage that flags quotients too large for the quotient width.
// -----------------------------------------------------------------------------
module awk_div
   import awk_pkg::*;
#(
   parameter int XW = 36,
   parameter int YW = 18
) (
   input  logic              clock,
   input  logic [XW-1:0]     x,
   input  logic [YW-1:0]     y,
   output logic [DIV_QW-1:0] q,
   output logic              sat
);
   localparam int CMPW = XW + YW + DIV_QW;

   logic [XW-1:0]     r_ff   [0:DIV_QW];
   logic [YW-1:0]     y_ff   [0:DIV_QW];
   logic [DIV_QW-1:0] q_ff   [0:DIV_QW];
   logic              sat_ff [0:DIV_QW];

   always_ff @(posedge clock) begin
      r_ff[0]   <= x;
      y_ff[0]   <= y;
      q_ff[0]   <= '0;
      sat_ff[0] <= (CMPW'(x) >= (CMPW'(y) << DIV_QW));
   end

   genvar k;
   generate
      for (k = 1; k <= DIV_QW; k++) begin : g_stage
         logic [CMPW-1:0] ys, rx;
         logic            ge;
         assign ys = CMPW'(y_ff[k-1]) << (DIV_QW - k);
         assign rx = CMPW'(r_ff[k-1]);
         assign ge = (rx >= ys);
         always_ff @(posedge clock) begin
            r_ff[k]   <= ge ? XW'(rx - ys) : r_ff[k-1];
            y_ff[k]   <= y_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (ge ? (DIV_QW'(1) << (DIV_QW - k)) : '0);
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   endgenerate

   assign q   = q_ff[DIV_QW];
   assign sat = sat_ff[DIV_QW];
endmodule

### hw/rtl/awk_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awk_back
// Computes steering angle and wheel speeds from classified items in a
// free-running pipeline and buffers results in a credit-guarded queue.
// -----------------------------------------------------------------------------
module awk_back
   import awk_pkg::*;
#(
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata
);
   localparam int CRW = $clog2(OUT_DEPTH + 1);

   logic [CRW-1:0]     credit_ff, credit_in;
   meta_type           meta_ff [1:BACK_LAT];
   meta_type           meta_in [1:BACK_LAT];
   logic               out_hs, of_full, of_empty, of_push;

   logic [16:0]        d_c;
   logic signed [16:0] sw_c;
   logic [XYW-1:0]     cx_c, cy_c, wlaw_c;
   logic [16:0]        d1_ff, d2_ff, d3_ff;
   logic signed [33:0] pv1_ff;
   logic signed [29:0] delta1_ff;
   logic [XYW-1:0]     cx1_ff, cy1_ff;
   logic signed [34:0] nl2_ff, nr2_ff;
   logic [26:0]        dk2_ff, dk3_ff, ry4_ff;
   logic [34:0]        al3_ff, ar3_ff;
   logic [35:0]        sxl4_ff, sxr4_ff;
   logic [17:0]        sy4_ff;
   logic [50:0]        rxl4_ff, rxr4_ff;
   logic [10:0]        angle;
   logic [10:0]        a_dly_ff [1:STEER_DLY];
   logic [DIV_QW-1:0]  qsl, qsr, qrl, qrr;
   logic               ssl, ssr, srl, srr;
   logic [11:0]        steer;
   logic [15:0]        spd_l, spd_r;
   logic [16:0]        rpm_l, rpm_r;
   logic [77:0]        res;
   meta_type           mo;

   function automatic logic [15:0] spd_sat(input logic [DIV_QW-1:0] q,
                                           input logic s, input logic neg);
      logic [16:0] m;
      if (neg) begin
         m = (s || q > 17'd32768) ? 17'd32768 : q;
         m = -m;
      end else begin
         m = (s || q > 17'd32767) ? 17'd32767 : q;
      end
      return m[15:0];
   endfunction

   function automatic logic [16:0] rpm_sat(input logic [DIV_QW-1:0] q,
                                           input logic s, input logic neg);
      logic [16:0] m;
      m = (s || q[16]) ? 17'd65535 : q;
      return neg ? -m : m;
   endfunction

   assign q_pop  = !q_empty && (credit_ff < CRW'(OUT_DEPTH));
   assign out_hs = rsp_tvalid && rsp_tready;

   always_comb begin
      credit_in = credit_ff;
      if (q_pop && !out_hs) begin
         credit_in = credit_ff + 1'b1;
      end else if (out_hs && !q_pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_comb begin
      case (cmd.kind)
         KIND_NORMAL: begin
            d_c  = 17'd2000;
            sw_c = $signed({cmd.w[15], cmd.w});
         end
         KIND_CUT: begin
            d_c  = {cfg.min_radius, 1'b0};
            sw_c = cmd.w[15] ? -$signed(cmd.av) : $signed(cmd.av);
         end
         default: begin
            d_c  = 17'd1;
            sw_c = '0;
         end
      endcase
      wlaw_c = XYW'(cfg.wheelbase * cmd.aw);
      case (cmd.kind)
         KIND_NORMAL: begin
            cx_c = XYW'(cmd.av1000);
            cy_c = wlaw_c;
         end
         KIND_CUT: begin
            cx_c = XYW'(cfg.min_radius);
            cy_c = XYW'(cfg.wheelbase);
         end
         default: begin
            cx_c = XYW'(1);
            cy_c = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      d1_ff     <= d_c;
      pv1_ff    <= cmd.v * $signed({1'b0, d_c});
      delta1_ff <= $signed({1'b0, cfg.track_width}) * sw_c;
      cx1_ff    <= cx_c;
      cy1_ff    <= cy_c;
      nl2_ff    <= 35'(pv1_ff) - 35'(delta1_ff);
      nr2_ff    <= 35'(pv1_ff) + 35'(delta1_ff);
      d2_ff     <= d1_ff;
      dk2_ff    <= 27'(d1_ff * 27'd1000);
      al3_ff    <= nl2_ff[34] ? 35'(-nl2_ff) : 35'(nl2_ff);
      ar3_ff    <= nr2_ff[34] ? 35'(-nr2_ff) : 35'(nr2_ff);
      d3_ff     <= d2_ff;
      dk3_ff    <= dk2_ff;
      sxl4_ff   <= {al3_ff, 1'b0} + 36'(d3_ff);
      sxr4_ff   <= {ar3_ff, 1'b0} + 36'(d3_ff);
      sy4_ff    <= {d3_ff, 1'b0};
      rxl4_ff   <= 51'(al3_ff * cfg.drive_ratio);
      rxr4_ff   <= 51'(ar3_ff * cfg.drive_ratio);
      ry4_ff    <= dk3_ff;
      a_dly_ff[1] <= angle;
      for (int k = 2; k <= STEER_DLY; k++) begin
         a_dly_ff[k] <= a_dly_ff[k-1];
      end
   end

   awk_cordic u_cordic (.clock(clock), .x(cx1_ff), .y(cy1_ff), .angle(angle));

   awk_div #(.XW(36), .YW(18)) u_div_sl (
      .clock(clock), .x(sxl4_ff), .y(sy4_ff), .q(qsl), .sat(ssl));
   awk_div #(.XW(36), .YW(18)) u_div_sr (
      .clock(clock), .x(sxr4_ff), .y(sy4_ff), .q(qsr), .sat(ssr));
   awk_div #(.XW(51), .YW(27)) u_div_rl (
      .clock(clock), .x(rxl4_ff), .y(ry4_ff), .q(qrl), .sat(srl));
   awk_div #(.XW(51), .YW(27)) u_div_rr (
      .clock(clock), .x(rxr4_ff), .y(ry4_ff), .q(qrr), .sat(srr));

   always_comb begin
      meta_in[1].valid    = q_pop;
      meta_in[1].straight = (cmd.kind == KIND_ZERO) || (cmd.kind == KIND_STRAIGHT);
      meta_in[1].left     = cmd.left;
      meta_in[1].negl     = 1'b0;
      meta_in[1].negr     = 1'b0;
      for (int k = 2; k <= BACK_LAT; k++) begin
         meta_in[k] = meta_ff[k-1];
      end
      meta_in[3].negl = nl2_ff[34];
      meta_in[3].negr = nr2_ff[34];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         for (int k = 1; k <= BACK_LAT; k++) begin
            meta_ff[k] <= '0;
         end
      end else begin
         credit_ff <= credit_in;
         for (int k = 1; k <= BACK_LAT; k++) begin
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   assign mo    = meta_ff[BACK_LAT];
   assign steer = mo.straight ? {1'b0, STRAIGHT_MRAD} :
                  mo.left ? {1'b0, STRAIGHT_MRAD} + {1'b0, a_dly_ff[STEER_DLY]} :
                            {1'b0, STRAIGHT_MRAD} - {1'b0, a_dly_ff[STEER_DLY]};
   assign spd_l = spd_sat(qsl, ssl, mo.negl);
   assign spd_r = spd_sat(qsr, ssr, mo.negr);
   assign rpm_l = rpm_sat(qrl, srl, mo.negl);
   assign rpm_r = rpm_sat(qrr, srr, mo.negr);
   assign res   = {rpm_r, rpm_l, spd_r, spd_l, steer};
   assign of_push = mo.valid;

   logic [77:0] of_dout;

   awk_fifo #(.WIDTH(78), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock(clock), .reset(reset), .push(of_push), .din(res), .pop(out_hs),
      .dout(of_dout), .full(of_full), .empty(of_empty));

   assign rsp_tvalid = !of_empty;
   assign rsp_tdata  = {2'b00, of_dout};

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRW'(OUT_DEPTH))
      else $error("result credit count above queue depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      of_push |-> !of_full)
      else $error("result written into a full queue");
   a_valid_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> credit_ff != '0)
      else $error("result offered without an outstanding item");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ackermann wheel speed block.
//
// A driver feeds twist items from a queue and a monitor checks every result
// against a behavioral model of the steering and wheel speed arithmetic. The
// run covers directed corner items, several register settings and random
// items under changing source idling and sink stalling, including one long
// sink hold-off that backs the block up into its input.
// -----------------------------------------------------------------------------
module tb
   import awk_pkg::*;
();

   typedef struct packed {
      logic signed [15:0] yaw_rate;
      logic signed [15:0] linear_speed;
   } twist_type;

   typedef struct {
      logic [11:0]        steer_angle;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [16:0] left_rpm;
      logic signed [16:0] right_rpm;
   } wheels_type;

   localparam logic [3:0] REG_DRIVE_RATIO = {ADDR_DRIVE_RATIO, 2'b00};
   localparam logic [3:0] REG_TRACK_WIDTH = {ADDR_TRACK_WIDTH, 2'b00};
   localparam logic [3:0] REG_WHEELBASE   = {ADDR_WHEELBASE, 2'b00};
   localparam logic [3:0] REG_MIN_RADIUS  = {ADDR_MIN_RADIUS, 2'b00};
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_taken = 1'b0;

   twist_type  pending_twists[$];
   wheels_type expected_wheels[$];
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         hold_cycles = 0;
   int         failures = 0;
   int         accepted = 0;

   logic [15:0] drive_ratio;
   logic [11:0] track_width;
   logic [11:0] wheelbase;
   logic [15:0] min_radius;

   twist_to_ackermann_wheel_speeds uut (.*);

   always #5 clock = ~clock;

   function automatic longint shift_tz(longint v, int s);
      return v >= 0 ? (v >>> s) : -((-v) >>> s);
   endfunction

   function automatic longint cordic_mrad(longint x, longint y);
      longint z, m, dx, dy;
      longint angles[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
      z = 0;
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < 16; i++) begin
         dx = shift_tz(y, i);
         dy = shift_tz(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += angles[i];
         end else begin
            x -= dx; y += dy; z -= angles[i];
         end
      end
      if (z < 0) z = 0;
      m = (z * 1000 + 32768) >>> 16;
      return m > 1571 ? 1571 : m;
   endfunction

   function automatic longint wheel_mm_s(longint n, longint d);
      longint a, q;
      a = n < 0 ? -n : n;
      q = (2 * a + d) / (2 * d);
      if (n < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic longint motor_rpm(longint n, longint d, longint ratio);
      longint q;
      q = (n * ratio) / (d * 1000);
      if (q > 65535) q = 65535;
      if (q < -65535) q = -65535;
      return q;
   endfunction

   function automatic wheels_type ackermann_wheels(twist_type t);
      wheels_type r;
      longint v, w, av, aw, tw, rm, steer, nl, nr, d, a, delta;
      v = t.linear_speed;
      w = t.yaw_rate;
      av = v < 0 ? -v : v;
      aw = w < 0 ? -w : w;
      tw = track_width;
      rm = min_radius;
      steer = 1571;
      if (v == 0) begin
         nl = 0; nr = 0; d = 1;
      end else if (w == 0) begin
         nl = v; nr = v; d = 1;
      end else begin
         if (1000 * av <= rm * aw) begin
            d = 2 * rm;
            delta = (w > 0 ? av : -av) * tw;
            a = cordic_mrad(rm, wheelbase);
         end else begin
            d = 2000;
            delta = tw * w;
            a = cordic_mrad(1000 * av, longint'(wheelbase) * aw);
         end
         nl = v * d - delta;
         nr = v * d + delta;
         steer = ((v > 0) == (w > 0)) ? 1571 + a : 1571 - a;
      end
      r.steer_angle = steer[11:0];
      r.left_speed  = 16'(wheel_mm_s(nl, d));
      r.right_speed = 16'(wheel_mm_s(nr, d));
      r.left_rpm    = 17'(motor_rpm(nl, d, drive_ratio));
      r.right_rpm   = 17'(motor_rpm(nr, d, drive_ratio));
      return r;
   endfunction

   // Items are predicted at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_wheels.push_back(ackermann_wheels(twist_type'(req_tdata)));
         accepted++;
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Driver: items leave the queue once the previous one has been accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_twists.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tdata  <= pending_twists.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      wheels_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_wheels.size() == 0) begin
            $error("result item with none expected: %h", rsp_tdata);
            failures++;
         end else begin
            e = expected_wheels.pop_front();
            if (rsp_tdata[11:0] !== e.steer_angle) begin
               $error("steer_angle expected %0d got %0d", e.steer_angle, rsp_tdata[11:0]);
               failures++;
            end
            if (rsp_tdata[27:12] !== e.left_speed) begin
               $error("left_speed expected %0d got %0d", e.left_speed,
                      $signed(rsp_tdata[27:12]));
               failures++;
            end
            if (rsp_tdata[43:28] !== e.right_speed) begin
               $error("right_speed expected %0d got %0d", e.right_speed,
                      $signed(rsp_tdata[43:28]));
               failures++;
            end
            if (rsp_tdata[60:44] !== e.left_rpm) begin
               $error("left_rpm expected %0d got %0d", e.left_rpm,
                      $signed(rsp_tdata[60:44]));
               failures++;
            end
            if (rsp_tdata[77:61] !== e.right_rpm) begin
               $error("right_rpm expected %0d got %0d", e.right_rpm,
                      $signed(rsp_tdata[77:61]));
               failures++;
            end
         end
      end
   end

   task automatic write_reg(logic [3:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (addr)
         REG_DRIVE_RATIO: drive_ratio = value[15:0];
         REG_TRACK_WIDTH: track_width = value[11:0];
         REG_WHEELBASE:   wheelbase = value[11:0];
         REG_MIN_RADIUS:  min_radius = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int ratio, int tw, int wb, int rmin);
      write_reg(REG_DRIVE_RATIO, ratio);
      write_reg(REG_TRACK_WIDTH, tw);
      write_reg(REG_WHEELBASE, wb);
      write_reg(REG_MIN_RADIUS, rmin);
   endtask

   task automatic wait_drained();
      while (pending_twists.size() > 0 || req_tvalid || expected_wheels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_twist(int v, int w);
      twist_type t;
      t.linear_speed = 16'(v);
      t.yaw_rate = 16'(w);
      pending_twists.push_back(t);
   endtask

   task automatic queue_random(int count);
      int v, w;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5))
            0: begin v = $urandom; w = $urandom; end
            1: begin v = $urandom_range(3000) - 1500; w = $urandom_range(8000) - 4000; end
            2: begin v = $urandom_range(1) ? 32767 : -32768; w = $urandom; end
            3: begin v = $urandom; w = $urandom_range(1) ? 0 : ($urandom_range(1) ? 32767 : -32768); end
            4: begin v = $urandom_range(200) - 100; w = $urandom_range(20000) - 10000; end
            default: begin v = $urandom_range(1) ? 0 : $urandom; w = $urandom_range(2) - 1; end
         endcase
         queue_twist(v, w);
      end
   endtask

   task automatic run_phase(int idle, int stall, int count);
      idle_pct = idle;
      stall_pct = stall;
      queue_random(count);
      wait_drained();
   endtask

   initial begin
      drive_ratio = 1000; track_width = 327; wheelbase = 300; min_radius = 350;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_twist(0, 0);
      queue_twist(0, 1000);
      queue_twist(500, 0);
      queue_twist(-500, 0);
      queue_twist(32767, 0);
      queue_twist(-32768, 0);
      queue_twist(1000, 1000);
      queue_twist(1000, -1000);
      queue_twist(-1000, 1000);
      queue_twist(-1000, -1000);
      queue_twist(350, 1000);
      queue_twist(351, 1000);
      queue_twist(100, 32767);
      queue_twist(-100, -32768);
      queue_twist(32767, 32767);
      queue_twist(-32768, -32768);
      queue_twist(32767, 1);
      queue_twist(1, -32768);
      wait_drained();

      set_geometry(65535, 4095, 4095, 0);
      run_phase(0, 0, 60);
      set_geometry(0, 1, 1, 65535);
      run_phase(74, 0, 60);
      set_geometry(1000, 4095, 1, 1);
      run_phase(0, 74, 60);

      set_geometry(2000, 500, 450, 600);
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 300;
      queue_random(120);
      wait_drained();

      set_geometry(1500, 327, 300, 350);
      run_phase(25, 25, 140);
      set_geometry($urandom_range(65535), $urandom_range(4095, 1),
                   $urandom_range(4095, 1), $urandom_range(65535));
      run_phase(0, 0, 130);
      set_geometry(1000, 327, 300, 350);
      run_phase(25, 25, 130);

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
